// File: design/weighted_string_hash_mod_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for weighted_string_hash_mod_top
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_STRING_HASH_MOD_TOP_MACROS_SVH
`define WEIGHTED_STRING_HASH_MOD_TOP_MACROS_SVH

// same-cycle implication
`define WSHM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wshm assertion failed");

// next-cycle implication
`define WSHM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wshm assertion failed");

`endif

// File: design/wshm_pkg.sv
// ----------------------------------------------------------------------------
// wshm_pkg
// Shared types and constants of the weighted string hash block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wshm_pkg;

    localparam int SUM_WIDTH_DEF = 24;
    localparam int KEY_W         = 8;
    localparam int WEIGHT_W      = 16;
    localparam int MOD_W         = 24;
    localparam int PROD_W        = KEY_W + WEIGHT_W;
    localparam int WEIGHT_COUNT  = 7;
    localparam int POS_W         = 3;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 24;

    localparam logic [MOD_W-1:0]    TABLE_SIZE_RST = MOD_W'(65536);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST     = WEIGHT_W'(1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FIRST = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LAST  = CFG_IDX_W'(7);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_REM,
        S_WB
    } t_state;

    typedef struct packed {
        logic [MOD_W-1:0]                       table_size;
        logic [WEIGHT_COUNT-1:0][WEIGHT_W-1:0]  weight;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;   // one-cycle pulse, result valid
    } t_unit_sts;

endpackage

// File: design/wshm_cfg.sv
// ----------------------------------------------------------------------------
// wshm_cfg
// Configuration registers: table size and the seven position weights.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wshm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wshm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wshm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output wshm_pkg::t_cfg                   o_cfg
);

    wshm_pkg::t_cfg r_cfg;
    logic [wshm_pkg::POS_W-1:0] w_widx;

    assign w_widx = wshm_pkg::POS_W'(i_cfg_index - wshm_pkg::CFG_WEIGHT_FIRST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_size <= wshm_pkg::TABLE_SIZE_RST;
            for (int k = 0; k < wshm_pkg::WEIGHT_COUNT; k++) begin
                r_cfg.weight[k] <= wshm_pkg::WEIGHT_RST;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == wshm_pkg::CFG_TABLE_SIZE) begin
                r_cfg.table_size <= i_cfg_data[wshm_pkg::MOD_W-1:0];
            end else if (i_cfg_index inside
                         {[wshm_pkg::CFG_WEIGHT_FIRST:wshm_pkg::CFG_WEIGHT_LAST]}) begin
                r_cfg.weight[w_widx] <= i_cfg_data[wshm_pkg::WEIGHT_W-1:0];
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/wshm_mul.sv
// ----------------------------------------------------------------------------
// wshm_mul
// Bit-serial multiplier: magnitude times weight, one magnitude bit per cycle,
// MSB first (shift left, conditional add).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wshm_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [wshm_pkg::KEY_W-1:0]       i_mag,
    input  logic [wshm_pkg::WEIGHT_W-1:0]    i_weight,
    output wshm_pkg::t_unit_sts              o_sts,
    output logic [wshm_pkg::PROD_W-1:0]      o_product
);

    localparam int CNT_W = $clog2(wshm_pkg::KEY_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(wshm_pkg::KEY_W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [wshm_pkg::KEY_W-1:0]    r_mag;
    logic [wshm_pkg::WEIGHT_W-1:0] r_weight;
    logic [wshm_pkg::PROD_W-1:0]   r_prod;
    logic [wshm_pkg::PROD_W-1:0]   n_prod;

    assign n_prod = {r_prod[wshm_pkg::PROD_W-2:0], 1'b0}
                  + (r_mag[wshm_pkg::KEY_W-1] ? wshm_pkg::PROD_W'(r_weight)
                                               : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag    <= i_mag;
            r_weight <= i_weight;
            r_prod   <= '0;
        end else if (r_busy) begin
            r_mag  <= {r_mag[wshm_pkg::KEY_W-2:0], 1'b0};
            r_prod <= n_prod;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_product  = r_prod;

endmodule

// File: design/wshm_rem.sv
// ----------------------------------------------------------------------------
// wshm_rem
// Restoring remainder unit: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wshm_rem #(
    parameter int DIV_W = wshm_pkg::SUM_WIDTH_DEF + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DIV_W-1:0]              i_dividend,
    input  logic [wshm_pkg::MOD_W-1:0]    i_modulus,
    output wshm_pkg::t_unit_sts           o_sts,
    output logic [wshm_pkg::MOD_W-1:0]    o_remainder
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [DIV_W-1:0]             r_div;
    logic [wshm_pkg::MOD_W-1:0]   r_mod;
    logic [wshm_pkg::MOD_W-1:0]   r_rem;
    logic [wshm_pkg::MOD_W:0]     w_trial;
    logic [wshm_pkg::MOD_W:0]     w_diff;
    logic                         w_ge;

    // remainder stays below the modulus, so the trial fits in MOD_W+1 bits
    assign w_trial = {r_rem, r_div[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_mod};
    assign w_ge    = (w_trial >= {1'b0, r_mod});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_mod <= i_modulus;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= {r_div[DIV_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[wshm_pkg::MOD_W-1:0] : w_trial[wshm_pkg::MOD_W-1:0];
        end
    end

    assign o_sts.busy   = r_busy;
    assign o_sts.done   = r_done;
    assign o_remainder  = r_rem;

endmodule

// File: design/weighted_string_hash_mod_top.sv
// ----------------------------------------------------------------------------
// weighted_string_hash_mod_top
// Key bytes in, one bucket index out per key. Each byte goes through the
// bit-serial multiplier, then, after a hand-off, the bit-serial remainder
// unit, then write-back. One byte is in flight at a time; a finished index
// sits in the output register, so the next byte is taken while it waits. A
// table size of zero skips the reduction and the sum wraps at SUM_WIDTH
// bits. Keys must be at least one byte long.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "weighted_string_hash_mod_top_macros.svh"

module weighted_string_hash_mod_top #(
    parameter int SUM_WIDTH = wshm_pkg::SUM_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wshm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wshm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [wshm_pkg::KEY_W-1:0]       i_key_byte,
    input  logic                             i_last_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [wshm_pkg::MOD_W-1:0]       o_bucket_index
);

    localparam int ACC_W = ((SUM_WIDTH > wshm_pkg::PROD_W) ? SUM_WIDTH
                                                           : wshm_pkg::PROD_W) + 1;
    localparam logic [wshm_pkg::POS_W-1:0] POS_LAST =
        wshm_pkg::POS_W'(wshm_pkg::WEIGHT_COUNT - 1);

    wshm_pkg::t_cfg       w_cfg;
    wshm_pkg::t_unit_sts  w_mul_sts;
    wshm_pkg::t_unit_sts  w_rem_sts;
    wshm_pkg::t_state     r_state;
    wshm_pkg::t_state     n_state;

    logic                          r_last;
    logic [SUM_WIDTH-1:0]          r_sum;
    logic [SUM_WIDTH-1:0]          n_sum;
    logic [wshm_pkg::POS_W-1:0]    r_pos;
    logic [ACC_W-1:0]              r_dividend;
    logic [ACC_W-1:0]              w_dividend;
    logic [ACC_W-1:0]              w_sum_ext;
    logic                          r_out_valid;
    logic [wshm_pkg::MOD_W-1:0]    r_bucket;
    logic [wshm_pkg::KEY_W-1:0]    w_mag;
    logic [wshm_pkg::PROD_W-1:0]   w_product;
    logic [wshm_pkg::MOD_W-1:0]    w_rem;
    logic                          w_accept;
    logic                          w_rem_start;
    logic                          w_wb;
    logic                          w_out_free;

    wshm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // two's complement magnitude; 0x80 gives 128
    assign w_mag = i_key_byte[wshm_pkg::KEY_W-1] ? (~i_key_byte + wshm_pkg::KEY_W'(1))
                                                 : i_key_byte;

    wshm_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_mag     (w_mag),
        .i_weight  (w_cfg.weight[r_pos]),
        .o_sts     (w_mul_sts),
        .o_product (w_product)
    );

    assign w_dividend = ACC_W'(r_sum) + ACC_W'(w_product);

    wshm_rem #(
        .DIV_W (ACC_W)
    ) u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_rem_start),
        .i_dividend  (w_dividend),
        .i_modulus   (w_cfg.table_size),
        .o_sts       (w_rem_sts),
        .o_remainder (w_rem)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wshm_pkg::S_IDLE: if (w_accept)       n_state = wshm_pkg::S_MUL;
            wshm_pkg::S_MUL:  if (w_mul_sts.done) n_state = wshm_pkg::S_REM;
            wshm_pkg::S_REM:  if (w_rem_sts.done) n_state = wshm_pkg::S_WB;
            wshm_pkg::S_WB:   if (w_wb)           n_state = wshm_pkg::S_IDLE;
            default:                              n_state = wshm_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_rem_start = 1'b0;
        w_wb        = 1'b0;
        case (r_state)
            wshm_pkg::S_IDLE: o_in_stall  = 1'b0;
            wshm_pkg::S_MUL:  w_rem_start = w_mul_sts.done;
            wshm_pkg::S_REM:  w_wb        = 1'b0;
            wshm_pkg::S_WB:   w_wb        = !r_last || w_out_free;
            default:          o_in_stall  = 1'b1;
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    // zero table size means no reduction
    assign n_sum = (w_cfg.table_size == '0) ? r_dividend[SUM_WIDTH-1:0]
                                            : SUM_WIDTH'(w_rem);
    assign w_sum_ext = ACC_W'(n_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wshm_pkg::S_IDLE;
            r_sum       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wb) begin
                if (r_last) begin
                    r_sum <= '0;
                    r_pos <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_pos <= (r_pos == POS_LAST) ? '0 : r_pos + wshm_pkg::POS_W'(1);
                end
            end
            if (w_wb && r_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_last_byte;
        end
        if (w_rem_start) begin
            r_dividend <= w_dividend;
        end
        if (w_wb && r_last) begin
            r_bucket <= w_sum_ext[wshm_pkg::MOD_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bucket_index = r_bucket;

    `WSHM_ASSERT_NOW(a_idle_units, !o_in_stall, !w_mul_sts.busy && !w_rem_sts.busy)
    `WSHM_ASSERT_NOW(a_rem_range, w_rem_sts.done && (w_cfg.table_size != '0),
                     w_rem < w_cfg.table_size)
    `WSHM_ASSERT_NEXT(a_key_end, w_wb && r_last,
                      o_out_valid && (r_sum == '0) && (r_pos == '0))
    `WSHM_ASSERT_NOW(a_pos_range, r_state == wshm_pkg::S_WB, r_pos <= POS_LAST)

endmodule
